>>> src/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// Command and result item structs, command and status codes, cell control group.
// No dependencies.
`default_nettype none

package ole_pkg;

  localparam int OLE_DEPTH = 16;
  localparam int OLE_VALUE_W = 32;
  localparam int OLE_COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_APPEND   = 3'd1,
    CMD_PUSH     = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_CONTAINS = 3'd4
  } ole_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } ole_status_t;

  typedef struct packed {
    logic [2:0]                     command;
    logic [7:0]                     position;
    logic signed [OLE_VALUE_W-1:0]  value;
  } ole_cmd_t;

  typedef struct packed {
    logic                    found;
    logic [OLE_COUNT_W-1:0]  count;
    logic [1:0]              status;
  } ole_res_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic load_match;
    logic search;
  } ole_cell_ctl_t;

endpackage

`default_nettype wire

>>> src/ordered_list_engine.sv
// Ordered list engine top level: command decode, count, result register, cell row.
// Depends on ole_pkg and ole_cell.
//
//   channel | signals                    | item
//   command | cmd_valid, cmd_ready, cmd  | ole_cmd_t  (command, position, value)
//   result  | res_valid, res_ready, res  | ole_res_t  (found, count, status)
//
// Each command updates every cell at the edge that accepts it; the result item is
// registered from the OR-reduced cell match flags as the pending stage advances, which
// waits while an earlier result is held unaccepted.
// One command per cycle is sustained while results are taken.
// Reset clears the count, the match flags and both valid flags; entries stay as they are.
// A stalled result holds the pending stage, and then cmd_ready falls.
`default_nettype none

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int DEPTH = OLE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire ole_cmd_t cmd,
  output logic          res_valid,
  input  wire logic     res_ready,
  output ole_res_t      res
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      pending;
  logic [1:0]                pend_status;
  logic                      pend_search;
  logic                      accept;
  logic                      advance;
  logic                      full;
  logic                      beyond;
  logic                      is_ins;
  logic [1:0]                status_next;
  logic [CW-1:0]             cell_pos;
  ole_cell_ctl_t             ctl;
  logic [DEPTH-1:0]          match;
  logic signed [OLE_VALUE_W-1:0] entry [DEPTH];

  assign advance   = pending && (!res_valid || res_ready);
  assign cmd_ready = !pending || advance;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = count == DEPTH_C;
  assign beyond    = CMPW'(cmd.position) >= CMPW'(count);

  always_comb begin
    is_ins      = 1'b0;
    status_next = ST_OK;
    count_next  = count;
    cell_pos    = count;
    ctl         = '0;
    ctl.load_match = accept;
    case (cmd.command)
      CMD_INSERT, CMD_APPEND, CMD_PUSH: begin
        is_ins = 1'b1;
        if (cmd.command == CMD_PUSH) begin
          cell_pos = '0;
        end else if (cmd.command == CMD_INSERT && !beyond) begin
          cell_pos = CW'(cmd.position);
        end
      end
      CMD_DELETE: begin
        cell_pos = CW'(cmd.position);
        if (beyond) begin
          status_next = ST_ABSENT;
        end else begin
          ctl.del    = accept;
          count_next = count - 1'b1;
        end
      end
      CMD_CONTAINS: begin
        ctl.search = 1'b1;
      end
      default: begin
      end
    endcase
    if (is_ins) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        ctl.ins    = accept;
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pending <= 1'b1;
      end else if (advance) begin
        pending <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_search <= cmd.command == CMD_CONTAINS;
    end
    if (advance) begin
      res.found  <= |match;
      res.count  <= OLE_COUNT_W'(count);
      res.status <= pend_status;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [OLE_VALUE_W-1:0] left;
    logic signed [OLE_VALUE_W-1:0] right;
    if (i == 0) begin : g_head
      assign left = cmd.value;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = cmd.value;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    ole_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .pos   (cell_pos),
      .count (count),
      .value (cmd.value),
      .left  (left),
      .right (right),
      .entry (entry[i]),
      .match (match[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("count beyond depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow count");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    accept && status_next == ST_FULL |=> count == DEPTH_C)
    else $error("full refusal with room left");

  a_found_only_search: assert property (@(posedge clk) disable iff (rst)
    pending && !pend_search |-> match == '0)
    else $error("match flag set outside contains");

endmodule

`default_nettype wire

>>> src/ole_cell.sv
// One slot of the ordered list: holds an entry and its registered match flag.
// Takes from its left neighbour on insert, from its right neighbour on delete.
// Depends on ole_pkg.
`default_nettype none

module ole_cell
  import ole_pkg::*;
#(
  parameter int DEPTH = OLE_DEPTH,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ole_cell_ctl_t                 ctl,
  input  wire logic [CW-1:0]                 pos,
  input  wire logic [CW-1:0]                 count,
  input  wire logic signed [OLE_VALUE_W-1:0] value,
  input  wire logic signed [OLE_VALUE_W-1:0] left,
  input  wire logic signed [OLE_VALUE_W-1:0] right,
  output logic signed [OLE_VALUE_W-1:0]      entry,
  output logic                               match
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic held;

  assign held = IDX_C < count;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (IDX_C == pos) begin
        entry <= value;
      end else if (IDX_C > pos) begin
        entry <= left;
      end
    end else if (ctl.del && IDX_C >= pos) begin
      entry <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.load_match) begin
      match <= ctl.search && held && (entry == value);
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for ordered_list_engine: directed edge cases, full list, output stall, result pauses and random mix.
// Predicts every result from its own list model; depends on ole_pkg and the engine RTL.
module testbench;
  import ole_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] CMD_CODE_MAX = 3'd7;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  ole_cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  ole_res_t res;

  logic signed [31:0] held_values[$];
  ole_res_t expected_results[$];
  ole_res_t want_res;
  int error_count = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int rx_left = 0;

  ordered_list_engine DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic ole_res_t predict_list_command(input ole_cmd_t c);
    ole_res_t r;
    int unsigned pos;
    bit full;
    r = '0;
    r.status = ST_OK;
    pos = c.position;
    full = held_values.size() >= OLE_DEPTH;
    case (c.command)
      CMD_INSERT: begin
        if (full) r.status = ST_FULL;
        else held_values.insert(pos < held_values.size() ? pos : held_values.size(), c.value);
      end
      CMD_APPEND: begin
        if (full) r.status = ST_FULL;
        else held_values.push_back(c.value);
      end
      CMD_PUSH: begin
        if (full) r.status = ST_FULL;
        else held_values.push_front(c.value);
      end
      CMD_DELETE: begin
        if (pos >= held_values.size()) r.status = ST_ABSENT;
        else held_values.delete(pos);
      end
      CMD_CONTAINS: begin
        foreach (held_values[i])
          if (held_values[i] == c.value) r.found = 1'b1;
      end
      default: ;
    endcase
    r.count = OLE_COUNT_W'(held_values.size());
    return r;
  endfunction

  function automatic ole_cmd_t make_cmd(input logic [2:0] code, input int unsigned pos,
                                        input logic signed [31:0] v);
    ole_cmd_t c;
    c.command = code;
    c.position = pos[7:0];
    c.value = v;
    return c;
  endfunction

  function automatic ole_cmd_t random_list_command(input bit grow);
    logic [2:0] code;
    int unsigned pos;
    logic signed [31:0] v;
    int r;
    int n;
    n = held_values.size();
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 20) code = CMD_INSERT;
      else if (r < 35) code = CMD_APPEND;
      else if (r < 50) code = CMD_PUSH;
      else if (r < 65) code = CMD_DELETE;
      else if (r < 95) code = CMD_CONTAINS;
      else code = 3'($urandom_range(CMD_CONTAINS + 1, CMD_CODE_MAX));
    end else begin
      if (r < 10) code = CMD_INSERT;
      else if (r < 17) code = CMD_APPEND;
      else if (r < 25) code = CMD_PUSH;
      else if (r < 65) code = CMD_DELETE;
      else if (r < 95) code = CMD_CONTAINS;
      else code = 3'($urandom_range(CMD_CONTAINS + 1, CMD_CODE_MAX));
    end
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, 255);
    else pos = $urandom_range(0, n);
    r = $urandom_range(0, 99);
    if (r < 40) v = $urandom;
    else if (r < 55) v = $signed($urandom_range(0, 7)) - 4;
    else if (r < 65) begin
      case ($urandom_range(0, 3))
        0: v = VALUE_MAX;
        1: v = VALUE_MIN;
        2: v = '0;
        default: v = -1;
      endcase
    end else if (n > 0) begin
      v = held_values[$urandom_range(0, n - 1)];
      if ($urandom_range(0, 2) == 0) v = v ^ (32'sd1 << $urandom_range(0, 31));
    end else v = $urandom;
    return make_cmd(code, pos, v);
  endfunction

  task automatic send_command(input ole_cmd_t c);
    int gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) expected_results.push_back(predict_list_command(cmd));
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with none expected: found %0d count %0d status %0d",
                 res.found, res.count, res.status);
          error_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (res.found !== want_res.found) begin
            $error("found: expected %0d, actual %0d", want_res.found, res.found);
            error_count++;
          end
          if (res.count !== want_res.count) begin
            $error("count: expected %0d, actual %0d", want_res.count, res.count);
            error_count++;
          end
          if (res.status !== want_res.status) begin
            $error("status: expected %0d, actual %0d", want_res.status, res.status);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      res_ready <= 1'b0;
      rx_left <= HOLD_CYCLES;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (no_idle || $urandom_range(0, 99) < 60) begin
      res_ready <= 1'b1;
      rx_left <= $urandom_range(0, 12);
    end else begin
      res_ready <= 1'b0;
      rx_left <= 1 + idle_length();
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_edge_cases();
    send_command(make_cmd(CMD_CONTAINS, 0, '0));
    send_command(make_cmd(CMD_DELETE, 0, '0));
    send_command(make_cmd(CMD_INSERT, 255, VALUE_MAX));
    send_command(make_cmd(CMD_APPEND, 0, VALUE_MIN));
    send_command(make_cmd(CMD_PUSH, 255, -1));
    send_command(make_cmd(CMD_INSERT, 1, '0));
    send_command(make_cmd(CMD_INSERT, 4, 32'sh5a5a5a5a));
    send_command(make_cmd(CMD_CONTAINS, 255, VALUE_MAX));
    send_command(make_cmd(CMD_CONTAINS, 0, VALUE_MIN));
    send_command(make_cmd(CMD_CONTAINS, 0, -1));
    send_command(make_cmd(CMD_CONTAINS, 0, VALUE_MAX - 1));
    send_command(make_cmd(CMD_CONTAINS, 0, 32'sh5a5a5a5b));
    send_command(make_cmd(CMD_DELETE, 5, '0));
    send_command(make_cmd(CMD_DELETE, 255, VALUE_MAX));
    send_command(make_cmd(CMD_DELETE, 4, '0));
    send_command(make_cmd(CMD_DELETE, 0, '0));
    send_command(make_cmd(3'(CMD_CONTAINS + 1), 255, VALUE_MAX));
    send_command(make_cmd(3'(CMD_CONTAINS + 2), 0, VALUE_MIN));
    send_command(make_cmd(CMD_CODE_MAX, 128, -1));
    send_command(make_cmd(CMD_CONTAINS, 0, VALUE_MAX));
    wait_drained();
  endtask

  task automatic test_full_list();
    int fill;
    fill = OLE_DEPTH - held_values.size();
    repeat (fill) send_command(make_cmd(CMD_APPEND, 0, $urandom));
    send_command(make_cmd(CMD_INSERT, 0, VALUE_MAX));
    send_command(make_cmd(CMD_APPEND, 0, VALUE_MIN));
    send_command(make_cmd(CMD_PUSH, 0, -1));
    send_command(make_cmd(CMD_CONTAINS, 0, held_values[OLE_DEPTH - 1]));
    send_command(make_cmd(CMD_DELETE, OLE_DEPTH, '0));
    send_command(make_cmd(CMD_DELETE, OLE_DEPTH - 1, '0));
    send_command(make_cmd(CMD_PUSH, 0, VALUE_MIN));
    send_command(make_cmd(CMD_INSERT, 255, '0));
    repeat (OLE_DEPTH) send_command(make_cmd(CMD_DELETE, 0, '0));
    send_command(make_cmd(CMD_DELETE, 0, '0));
    wait_drained();
  endtask

  task automatic test_output_stall();
    no_idle <= 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (40) send_command(random_list_command(1'b1));
    no_idle <= 1'b0;
    wait_drained();
  endtask

  task automatic test_pause_for_results();
    repeat (4) begin
      repeat ($urandom_range(5, 20)) send_command(random_list_command(1'($urandom_range(0, 1))));
      wait_drained();
    end
  endtask

  task automatic test_random_mix();
    bit grow;
    int n;
    grow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      n = held_values.size();
      if (grow && n >= OLE_DEPTH && $urandom_range(0, 7) == 0) grow = 1'b0;
      if (!grow && n == 0 && $urandom_range(0, 7) == 0) grow = 1'b1;
      send_command(random_list_command(grow));
    end
    no_idle <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_cases();
    test_full_list();
    test_output_stall();
    test_pause_for_results();
    test_random_mix();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result items never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
